>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define SEPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, gated off during reset.
`define SEPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

>>> hw/rtl/sept_pkg.sv
// Shared types and codes for the separator/enclosure tokenizer.
// No dependencies.
`default_nettype none

package sept_pkg;

  localparam int CHAR_W = 8;
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEP_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_PAIRS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_COUNT = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_PLAIN = 3'b010,
    MODE_ENCL  = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END     = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  // Byte classification against the configured sets
  typedef struct packed {
    logic is_sep;
    logic is_open;
    logic is_pair;
  } cls_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    kind_t             kind;
    logic              last;
  } res_t;

  // Up to three results caused by one input byte, in order
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    res_t       r2;
    logic [1:0] cnt;
  } batch_t;

endpackage

`default_nettype wire

>>> hw/rtl/sept_in_if.sv
// Input byte channel: valid/ready with the string byte and last flag.
// Depends on sept_pkg.
`default_nettype none

interface sept_in_if
  import sept_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sept_out_if.sv
// Result channel: valid/ready with token byte, kind and run_last.
// Depends on sept_pkg.
`default_nettype none

interface sept_out_if
  import sept_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic [1:0]        kind;
  logic              run_last;

  modport source (output valid, output out_char, output kind, output run_last,
                  input ready);
  modport sink   (input valid, input out_char, input kind, input run_last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sept_class.sv
// Configuration registers and parallel byte comparators.
// Depends on sept_pkg.
`default_nettype none

module sept_class
  import sept_pkg::*;
#(
  parameter int MAX_SEPARATORS = 8,
  parameter int MAX_ENCLOSURES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [CHAR_W-1:0]    c,
  input  wire logic [CHAR_W-1:0]    open_char,
  output cls_t                      cls
);

  localparam int SEP_W = 8 * MAX_SEPARATORS;
  localparam int ENC_W = 16 * MAX_ENCLOSURES;

  logic [SEP_W-1:0] sep_chars_r;
  logic [3:0]       sep_cnt_r;
  logic [ENC_W-1:0] enc_pairs_r;
  logic [2:0]       enc_cnt_r;
  logic [3:0]       sep_used;
  logic [2:0]       enc_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_chars_r <= '0;
      sep_cnt_r   <= '0;
      enc_pairs_r <= '0;
      enc_cnt_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SEP_CHARS: sep_chars_r <= cfg_wdata[SEP_W-1:0];
        REG_SEP_COUNT: sep_cnt_r   <= cfg_wdata[3:0];
        REG_ENC_PAIRS: enc_pairs_r <= cfg_wdata[ENC_W-1:0];
        REG_ENC_COUNT: enc_cnt_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // counts above the limits saturate
  assign sep_used = (sep_cnt_r > 4'(MAX_SEPARATORS)) ? 4'(MAX_SEPARATORS) : sep_cnt_r;
  assign enc_used = (enc_cnt_r > 3'(MAX_ENCLOSURES)) ? 3'(MAX_ENCLOSURES) : enc_cnt_r;

  always_comb begin
    cls = '0;
    for (int k = 0; k < MAX_SEPARATORS; k++) begin
      if ((4'(k) < sep_used) && (sep_chars_r[8*k +: 8] == c))
        cls.is_sep = 1'b1;
    end
    for (int k = 0; k < MAX_ENCLOSURES; k++) begin
      if (3'(k) < enc_used) begin
        if (enc_pairs_r[16*k +: 8] == c)
          cls.is_open = 1'b1;
        if ((enc_pairs_r[16*k +: 8] == open_char) && (enc_pairs_r[16*k+8 +: 8] == c))
          cls.is_pair = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sept_step.sv
// Parse state and next-result logic for one byte.
// Depends on sept_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sept_step
  import sept_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic [CHAR_W-1:0] c,
  input  wire logic              in_last,
  input  wire cls_t              cls,
  output logic [CHAR_W-1:0]      open_char,
  output batch_t                 batch
);

  mode_t             mode_r, mode_nxt;
  logic [CHAR_W-1:0] open_r, open_nxt;
  logic              has_r, has_nxt;

  logic  main_v, tail_v;
  res_t  main_res, tail_res, done_res;
  logic [1:0] cnt;
  logic  state_clear;

  assign open_char = open_r;

  always_comb begin
    mode_nxt = mode_r;
    open_nxt = open_r;
    has_nxt  = has_r;
    main_v   = 1'b0;
    main_res = '{ch: '0, kind: KIND_END, last: 1'b0};
    tail_v   = 1'b0;
    tail_res = '{ch: '0, kind: KIND_END, last: 1'b0};
    done_res = '{ch: '0, kind: KIND_DONE, last: 1'b0};

    case (mode_r)
      MODE_PLAIN: begin
        if (cls.is_sep) begin
          main_v   = 1'b1;
          mode_nxt = MODE_IDLE;
          has_nxt  = 1'b0;
        end else if (cls.is_open) begin
          main_v   = 1'b1;
          mode_nxt = MODE_ENCL;
          open_nxt = c;
          has_nxt  = 1'b0;
        end else begin
          main_v   = 1'b1;
          main_res = '{ch: c, kind: KIND_BYTE, last: 1'b0};
          has_nxt  = 1'b1;
        end
      end
      MODE_ENCL: begin
        if (cls.is_pair) begin
          main_v   = has_r;     // empty enclosed token gives nothing
          mode_nxt = MODE_IDLE;
          has_nxt  = 1'b0;
        end else begin
          main_v   = 1'b1;
          main_res = '{ch: c, kind: KIND_BYTE, last: 1'b0};
          has_nxt  = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (cls.is_sep) begin
          has_nxt = has_r;
        end else if (cls.is_open) begin
          mode_nxt = MODE_ENCL;
          open_nxt = c;
          has_nxt  = 1'b0;
        end else begin
          main_v   = 1'b1;
          main_res = '{ch: c, kind: KIND_BYTE, last: 1'b0};
          mode_nxt = MODE_PLAIN;
          has_nxt  = 1'b1;
        end
      end
    endcase

    // end of string closes whatever is open
    if (in_last) begin
      if (mode_nxt == MODE_PLAIN && has_nxt) begin
        tail_v = 1'b1;
      end else if (mode_nxt == MODE_ENCL && has_nxt) begin
        tail_v   = 1'b1;
        tail_res = '{ch: '0, kind: KIND_DISCARD, last: 1'b0};
      end
      mode_nxt = MODE_IDLE;
      open_nxt = '0;
      has_nxt  = 1'b0;
    end
  end

  // compact the three optional results into order
  assign cnt = 2'(main_v) + 2'(tail_v) + 2'(in_last);

  always_comb begin
    batch.cnt = cnt;
    batch.r0  = main_v ? main_res : (tail_v ? tail_res : done_res);
    batch.r1  = main_v ? (tail_v ? tail_res : done_res) : done_res;
    batch.r2  = done_res;
    batch.r0.last = (cnt == 2'd1);
    batch.r1.last = (cnt == 2'd2);
    batch.r2.last = (cnt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      open_r <= '0;
      has_r  <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      open_r <= open_nxt;
      has_r  <= has_nxt;
    end
  end

  assign state_clear = (mode_r == MODE_IDLE) && !has_r && (open_r == '0);

  `SEPT_ASSERT_NXT(a_last_clears_state, clk, rst_n, adv && in_last, state_clear)
  `SEPT_ASSERT_IMP(a_idle_has_no_bytes, clk, rst_n, mode_r == MODE_IDLE, !has_r)
  `SEPT_ASSERT_IMP(a_last_gives_results, clk, rst_n, adv && in_last, batch.cnt != 2'd0)

endmodule

`default_nettype wire

>>> hw/rtl/sept_obuf.sv
// Result buffer: holds the results of one byte and hands them out in order.
// Depends on sept_pkg, sept_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sept_obuf
  import sept_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire batch_t batch,
  output logic        free,
  sept_out_if.source  out_bus
);

  res_t       ent_r [3];
  logic [1:0] cnt_r;
  logic       xfer;
  logic       one_left;

  assign out_bus.valid    = (cnt_r != 2'd0);
  assign out_bus.out_char = ent_r[0].ch;
  assign out_bus.kind     = ent_r[0].kind;
  assign out_bus.run_last = ent_r[0].last;

  assign xfer     = out_bus.valid && out_bus.ready;
  assign one_left = (cnt_r == 2'd1);
  // empty now, or the final entry leaves this cycle
  assign free = (cnt_r == 2'd0) || (one_left && out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
    end else if (xfer) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r[0] <= batch.r0;
      ent_r[1] <= batch.r1;
      ent_r[2] <= batch.r2;
    end else if (xfer) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

  `SEPT_ASSERT_IMP(a_run_last_matches_count, clk, rst_n, out_bus.valid, out_bus.run_last == one_left)
  `SEPT_ASSERT_IMP(a_done_last, clk, rst_n, out_bus.valid && out_bus.kind == KIND_DONE, out_bus.run_last)

endmodule

`default_nettype wire

>>> hw/rtl/separator_enclosure_tokenizer.sv
// Top level of the separator/enclosure tokenizer.
// Depends on sept_pkg, sept_in_if, sept_out_if, sept_class, sept_step, sept_obuf.
`default_nettype none

//  Channel   Dir  Handshake      Payload
//  in_bus    in   valid/ready    in_char[7:0], in_last
//  out_bus   out  valid/ready    out_char[7:0], kind[1:0], run_last
//  cfg_*     in   cfg_we only    cfg_idx[1:0], cfg_wdata[63:0]
//
//  One byte per cycle while out_bus is ready: a byte with zero or one result moves
//  straight through; a byte with several results keeps the result buffer busy until
//  its last result leaves, and the next byte waits in the input register till then.
//  Each byte is held in the input register, then its results in the result buffer.
//  rst_n is synchronous; it clears config registers, parse state and valids.
//  A stall on out_bus backs up into the input register, then drops in_bus.ready.

module separator_enclosure_tokenizer
  import sept_pkg::*;
#(
  parameter int MAX_SEPARATORS = 8,
  parameter int MAX_ENCLOSURES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sept_in_if.sink                   in_bus,
  sept_out_if.source                out_bus,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Input register: holds one accepted byte until its results fit the buffer
  logic              in_v_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;

  logic              buf_free;
  logic              adv;          // byte moves into the result buffer
  logic              in_xfer;
  logic [CHAR_W-1:0] open_char;
  cls_t              cls;
  batch_t            batch;

  assign adv           = in_v_r && buf_free;
  assign in_bus.ready  = !in_v_r || buf_free;
  assign in_xfer       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_xfer) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_char_r <= in_bus.in_char;
      in_last_r <= in_bus.in_last;
    end
  end

  // Separator, opener and pair matches for the held byte
  sept_class #(
    .MAX_SEPARATORS (MAX_SEPARATORS),
    .MAX_ENCLOSURES (MAX_ENCLOSURES)
  ) u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .c         (in_char_r),
    .open_char (open_char),
    .cls       (cls)
  );

  // Parse state; state commits when the byte advances
  sept_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .c         (in_char_r),
    .in_last   (in_last_r),
    .cls       (cls),
    .open_char (open_char),
    .batch     (batch)
  );

  // Result buffer, one transfer per cycle on out_bus while out_bus is ready
  sept_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (adv),
    .batch   (batch),
    .free    (buf_free),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

>>> bench/separator_enclosure_tokenizer_test.sv
// Self-checking bench for the separator/enclosure tokenizer: directed strings,
// then random byte streams under several register settings, with random stalls.
// Depends on sept_pkg, sept_in_if, sept_out_if and the tokenizer top level.
`default_nettype none

import sept_pkg::*;

// Predicts the result stream of the tokenizer and checks what the block returns.
class token_scoreboard;
  int unsigned max_seps;
  int unsigned max_encs;
  logic [CFG_W-1:0] sep_chars;
  logic [3:0]       sep_cnt;
  logic [CFG_W-1:0] enc_pairs;
  logic [2:0]       enc_cnt;
  mode_t            mode;
  logic [7:0]       open_ch;
  logic             has_bytes;
  res_t             batch_q[$];
  res_t             expected_q[$];
  int unsigned      errors;
  int unsigned      checked;

  function new(int unsigned ms, int unsigned me);
    max_seps  = ms;
    max_encs  = me;
    sep_chars = '0;
    sep_cnt   = '0;
    enc_pairs = '0;
    enc_cnt   = '0;
    mode      = MODE_IDLE;
    open_ch   = '0;
    has_bytes = 1'b0;
    errors    = 0;
    checked   = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_SEP_CHARS: sep_chars = val;
      REG_SEP_COUNT: sep_cnt = val[3:0];
      REG_ENC_PAIRS: enc_pairs = val;
      REG_ENC_COUNT: enc_cnt = val[2:0];
      default: ;
    endcase
  endfunction

  function bit is_separator(logic [7:0] c);
    int unsigned n;
    int unsigned k;
    n = (sep_cnt > max_seps) ? max_seps : sep_cnt;
    for (k = 0; k < n; k++)
      if (sep_chars[8*k +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  function bit is_opener(logic [7:0] c);
    int unsigned n;
    int unsigned k;
    n = (enc_cnt > max_encs) ? max_encs : enc_cnt;
    for (k = 0; k < n; k++)
      if (enc_pairs[16*k +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Any pair with this opener may close the token.
  function bit closes(logic [7:0] o, logic [7:0] c);
    int unsigned n;
    int unsigned k;
    n = (enc_cnt > max_encs) ? max_encs : enc_cnt;
    for (k = 0; k < n; k++)
      if (enc_pairs[16*k +: 8] == o && enc_pairs[16*k+8 +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  function void add_result(logic [7:0] c, kind_t k);
    res_t r;
    r.ch   = (k == KIND_BYTE) ? c : 8'h00;
    r.kind = k;
    r.last = 1'b0;
    batch_q = {batch_q, r};
  endfunction

  function void note_input(logic [7:0] c, logic last);
    batch_q.delete();
    case (mode)
      MODE_PLAIN: begin
        if (is_separator(c)) begin
          add_result(8'h00, KIND_END);
          mode = MODE_IDLE;
          has_bytes = 1'b0;
        end else if (is_opener(c)) begin
          add_result(8'h00, KIND_END);
          mode = MODE_ENCL;
          open_ch = c;
          has_bytes = 1'b0;
        end else begin
          add_result(c, KIND_BYTE);
          has_bytes = 1'b1;
        end
      end
      MODE_ENCL: begin
        if (closes(open_ch, c)) begin
          if (has_bytes) add_result(8'h00, KIND_END);
          mode = MODE_IDLE;
          has_bytes = 1'b0;
        end else begin
          add_result(c, KIND_BYTE);
          has_bytes = 1'b1;
        end
      end
      default: begin
        mode = MODE_IDLE;
        // separators are skipped here; separator wins over opener
        if (!is_separator(c)) begin
          if (is_opener(c)) begin
            mode = MODE_ENCL;
            open_ch = c;
            has_bytes = 1'b0;
          end else begin
            add_result(c, KIND_BYTE);
            mode = MODE_PLAIN;
            has_bytes = 1'b1;
          end
        end
      end
    endcase
    if (last) begin
      if (mode == MODE_PLAIN && has_bytes) add_result(8'h00, KIND_END);
      else if (mode == MODE_ENCL && has_bytes) add_result(8'h00, KIND_DISCARD);
      add_result(8'h00, KIND_DONE);
      mode = MODE_IDLE;
      open_ch = 8'h00;
      has_bytes = 1'b0;
    end
    if (batch_q.size() > 0) batch_q[batch_q.size()-1].last = 1'b1;
    foreach (batch_q[i]) expected_q = {expected_q, batch_q[i]};
  endfunction

  function void report(string what, logic [7:0] exp_v, logic [7:0] got_v);
    errors++;
    $display("%0t mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
  endfunction

  function void check_result(logic [7:0] got_ch, logic [1:0] got_kind, logic got_last);
    res_t exp_r;
    checked++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t unexpected result: expected none, got char %h kind %0d last %b",
               $time, got_ch, got_kind, got_last);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got_ch !== exp_r.ch) report("out_char", exp_r.ch, got_ch);
    if (got_kind !== exp_r.kind) report("kind", {6'd0, exp_r.kind}, {6'd0, got_kind});
    if (got_last !== exp_r.last) report("run_last", {7'd0, exp_r.last}, {7'd0, got_last});
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module separator_enclosure_tokenizer_test;

  localparam int MAX_SEPS    = 8;
  localparam int MAX_ENCS    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;   // long receiver hold-off
  localparam int SETTLE      = 8;    // cycles past the last result before a write

  typedef enum logic [1:0] {
    RX_FREE,      // always ready
    RX_COIN,      // ready half the time
    RX_SPARSE,    // ready with a chance of one in four
    RX_PERIODIC   // fixed on/off pattern
  } rx_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  sept_in_if  in_bus();
  sept_out_if out_bus();

  separator_enclosure_tokenizer #(
    .MAX_SEPARATORS(MAX_SEPS),
    .MAX_ENCLOSURES(MAX_ENCS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  token_scoreboard sb;

  // Byte pool for one register setting: the configured bytes come from its first
  // six entries, so separators, openers and closers overlap and recur in the stream.
  logic [7:0] alphabet[8];

  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned settings_used = 0;
  int unsigned hold_requests = 0;

  // receiver-side state, owned by the receiver process
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_tick = 0;
  rx_style_t   rx_style = RX_FREE;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("separator_enclosure_tokenizer_test NOT OK");
      $finish;
    end
  end

  // Receiver: a randomly picked stall style, and a long hold-off whenever
  // the stimulus asks for one, so the result buffer fills and backs up the input.
  always @(negedge clk) begin
    rx_tick++;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      if (rx_tick % 48 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
      case (rx_style)
        RX_FREE:   out_bus.ready <= 1'b1;
        RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
        default:   out_bus.ready <= ((rx_tick % 11) < 7);
      endcase
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.out_char, out_bus.kind, out_bus.run_last);
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Offers one byte and returns once the transfer happened.
  task automatic push_byte(input logic [7:0] c, input logic l);
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.in_char <= c;
    in_bus.in_last <= l;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(c, l);
    bytes_sent++;
    if (l) strings_sent++;
  endtask

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
  endtask

  // Sender stops and waits until every predicted result has been seen; some
  // bytes have no result, so a SETTLE wait lets the block go quiet.
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Count words carry random upper bits: only the low bits of the register count.
  function automatic logic [CFG_W-1:0] count_word(input int unsigned cnt);
    logic [CFG_W-1:0] w;
    w = {$urandom(), $urandom()};
    w[3:0] = cnt[3:0];
    return w;
  endfunction

  task automatic configure_random(input logic [CFG_W-1:0] sep_cnt_word,
                                  input logic [CFG_W-1:0] enc_cnt_word);
    logic [CFG_W-1:0] seps;
    logic [CFG_W-1:0] pairs;
    int k;
    for (k = 0; k < 8; k++) alphabet[k] = 8'($urandom_range(0, 255));
    for (k = 0; k < 8; k++) seps[8*k +: 8] = alphabet[$urandom_range(0, 5)];
    for (k = 0; k < 4; k++) begin
      pairs[16*k +: 8]   = alphabet[$urandom_range(0, 5)];
      pairs[16*k+8 +: 8] = alphabet[$urandom_range(0, 5)];
    end
    write_register(REG_SEP_CHARS, seps);
    write_register(REG_SEP_COUNT, sep_cnt_word);
    write_register(REG_ENC_PAIRS, pairs);
    write_register(REG_ENC_COUNT, enc_cnt_word);
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return alphabet[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Random strings in bursts with random gaps; the last byte of a run always
  // closes its string. hold_at / pause_at name the item where the receiver
  // hold-off starts and where the sender waits for a full drain (-1: none).
  task automatic run_stream(input int n, input int hold_at, input int pause_at);
    int i;
    int burst_left;
    logic l;
    burst_left = $urandom_range(1, 24);
    for (i = 0; i < n; i++) begin
      if (i == hold_at) begin
        hold_requests++;
        burst_left = 40;   // keep offering while the receiver is held off
      end
      if (i == pause_at) drain();
      if (burst_left == 0) begin
        idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      l = (i == n - 1) || ($urandom_range(0, 9) == 0);
      push_byte(pick_byte(), l);
    end
    drain();
  endtask

  initial begin
    sb = new(MAX_SEPS, MAX_ENCS);
    in_bus.valid   = 1'b0;
    in_bus.in_char = 8'h00;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_SEP_CHARS;
    cfg_wdata      = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed setting: separators space, comma, bar; pairs ( ), ( ], " ", | !.
    // Bar is both separator and opener, so it must act as a separator.
    write_register(REG_SEP_CHARS, 64'h0000_0000_007C_2C20);
    write_register(REG_SEP_COUNT, 64'd3);
    write_register(REG_ENC_PAIRS, 64'h217C_2222_5D28_2928);
    write_register(REG_ENC_COUNT, 64'd4);
    settings_used++;

    push_byte(" ", 1'b0);      // separator while idle: skipped
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte(",", 1'b0);      // ends plain token
    push_byte("x", 1'b0);
    push_byte("(", 1'b0);      // opener ends plain token and opens an enclosure
    push_byte("y", 1'b0);
    push_byte(" ", 1'b0);      // separator inside an enclosure is content
    push_byte("]", 1'b0);      // second pair sharing the same opener closes it
    push_byte("(", 1'b0);
    push_byte(")", 1'b0);      // empty enclosure: nothing out
    push_byte("\"", 1'b0);
    push_byte("q", 1'b0);
    push_byte("\"", 1'b0);     // opener equal to closer
    push_byte("|", 1'b0);      // separator beats opener
    push_byte(8'h00, 1'b0);    // byte extremes as plain content
    push_byte(8'hFF, 1'b0);
    push_byte(" ", 1'b0);
    push_byte("(", 1'b0);
    push_byte("z", 1'b1);      // open enclosure with content at end: discarded
    push_byte("(", 1'b1);      // empty open enclosure at end: only done
    push_byte("k", 1'b1);      // byte, end and done from one input
    push_byte(" ", 1'b1);      // separator at end: only done
    drain();

    // Counts within range, long receiver hold-off partway through.
    configure_random(count_word($urandom_range(1, 8)), count_word($urandom_range(1, 4)));
    run_stream(80, 30, -1);

    // Full sets, with a mid-run sender pause until all results are back.
    configure_random(64'd8, 64'd4);
    run_stream(80, -1, 40);

    // Counts written as all ones: saturated to the maximum sets.
    configure_random('1, '1);
    run_stream(70, -1, -1);

    // Extreme bytes: 0xFF is the separator, 0x00 opens and closes.
    configure_random(64'd8, 64'd4);
    write_register(REG_SEP_CHARS, '1);
    write_register(REG_ENC_PAIRS, '0);
    alphabet[0] = 8'hFF;
    alphabet[1] = 8'h00;
    run_stream(50, -1, -1);

    // Empty sets: everything is content, strings end only at the flag.
    configure_random(count_word(0), count_word(0));
    run_stream(50, -1, -1);

    // Any count value, in or out of range.
    configure_random(count_word($urandom_range(0, 15)), count_word($urandom_range(0, 7)));
    run_stream(110, -1, -1);

    $display("sent %0d bytes in %0d strings over %0d register settings",
             bytes_sent, strings_sent, settings_used);
    $display("checked %0d results, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("separator_enclosure_tokenizer_test OK");
    end else begin
      $display("separator_enclosure_tokenizer_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
